FILE: rtl/core/b32ge_pkg.sv
// ----------------------------------------------------------------------------
// Base32 grouped encoder package
// Item types, configuration register indexes, character codes and the
// base32 alphabet lookup shared by the encoder and its stream interface users.
// ----------------------------------------------------------------------------
package b32ge_pkg;

    localparam int MAX_RESULTS = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHARS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_EN  = 1'd1;

    localparam logic [7:0] MAX_CHARS_RST = 8'd127;
    localparam logic       GROUP_EN_RST  = 1'b1;

    localparam logic [6:0] CHAR_SPACE = 7'h20;
    localparam logic [6:0] CHAR_NUL   = 7'h00;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic [6:0] out_char;
        logic       end_of_text;
        logic       truncated;
    } t_out_item;

    // RFC 4648 alphabet: A-Z then 2-7
    function automatic logic [6:0] sym_to_char(input logic [4:0] sym);
        logic [6:0] ch;
        if (sym < 5'd26) begin
            ch = 7'h41 + {2'b00, sym};
        end else begin
            ch = 7'h32 + {2'b00, sym - 5'd26};
        end
        return ch;
    endfunction

endpackage

FILE: rtl/core/b32ge_stream_if.sv
// ----------------------------------------------------------------------------
// Base32 encoder stream interface
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface b32ge_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

FILE: rtl/core/base32_grouped_encoder.sv
// ----------------------------------------------------------------------------
// Base32 grouped encoder
// An accepted byte passes the input register and then the result buffer to o_out.
// Throughput: one result per cycle while o_out is ready; the result buffer drains
//   one character per cycle and takes the next byte as its last character leaves.
// Reset (i_rst_n low, synchronous): pipeline empty, residue and counters zero,
//   max_chars 127, grouping on.
// ----------------------------------------------------------------------------
module base32_grouped_encoder #(
    parameter int GROUP_SIZE = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    b32ge_stream_if.sink                      i_in,
    b32ge_stream_if.source                    o_out,
    input  logic                              i_cfg_we,
    input  logic [b32ge_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [b32ge_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int GW = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
    localparam logic [GW:0] GS_LAST = (GW+1)'(GROUP_SIZE - 1);
    localparam int NW = $clog2(b32ge_pkg::MAX_RESULTS + 1);
    localparam int IW = $clog2(b32ge_pkg::MAX_RESULTS);

    // configuration
    logic [7:0] r_max_chars;
    logic       r_group_en;

    // encoder state
    logic [3:0]    r_residue, n_residue;
    logic [2:0]    r_rcnt, n_rcnt;
    logic [GW-1:0] r_gfill, n_gfill;
    logic [7:0]    r_chars, n_chars;
    logic          r_limit, n_limit;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_fin;

    // result buffer
    logic       r_buf_valid;
    logic [6:0] r_buf_char [b32ge_pkg::MAX_RESULTS];
    logic [NW-1:0] r_buf_cnt;
    logic [IW-1:0] r_buf_idx;
    logic       r_buf_eot;
    logic       r_buf_trunc;

    logic [6:0]    n_res [b32ge_pkg::MAX_RESULTS];
    logic [NW-1:0] n_nres;

    logic buf_last;
    logic out_xfer;
    logic advance;
    b32ge_pkg::t_out_item out_item;

    assign out_xfer = o_out.valid & o_out.ready;
    assign buf_last = (NW'(r_buf_idx) == r_buf_cnt - NW'(1));
    assign advance  = r_in_valid & (~r_buf_valid | (out_xfer & buf_last));
    assign i_in.ready = ~r_in_valid | advance;

    always_comb begin
        out_item.out_char    = r_buf_char[r_buf_idx];
        out_item.end_of_text = r_buf_eot & buf_last;
        out_item.truncated   = r_buf_trunc;
    end
    assign o_out.valid   = r_buf_valid;
    assign o_out.payload = out_item;

    // per-byte encoding
    always_comb begin
        logic [11:0]  acc;
        logic [3:0]   total;
        logic         two;
        logic [2:0]   left;
        logic [4:0]   sym [3];
        logic [2:0]   sym_v;
        logic [11:0]  shifted;
        logic [GW:0]  gf_inc;
        gf_inc  = '0;
        acc     = {r_residue, r_in_byte};
        total   = {1'b0, r_rcnt} + 4'd8;
        two     = (total >= 4'd10);
        shifted = acc >> (total - 4'd5);
        sym[0]  = shifted[4:0];
        shifted = acc >> (total - 4'd10);
        sym[1]  = shifted[4:0];
        left    = two ? 3'(total - 4'd10) : 3'(total - 4'd5);
        shifted = acc << (3'd5 - left);
        sym[2]  = shifted[4:0];
        sym_v   = {r_in_fin & (left != 3'd0), two, 1'b1};

        n_chars = r_chars;
        n_gfill = r_gfill;
        n_limit = r_limit;
        n_nres  = '0;
        for (int i = 0; i < b32ge_pkg::MAX_RESULTS; i++) begin
            n_res[i] = b32ge_pkg::CHAR_NUL;
        end

        for (int k = 0; k < 3; k++) begin
            if (sym_v[k]) begin
                if (n_chars >= r_max_chars) begin
                    n_limit = 1'b1;
                end else begin
                    if (n_gfill == '0 && n_chars != 8'd0 && r_group_en) begin
                        if (n_nres >= NW'(b32ge_pkg::MAX_RESULTS)) begin
                            n_limit = 1'b1;
                        end else begin
                            n_res[n_nres[IW-1:0]] = b32ge_pkg::CHAR_SPACE;
                            n_nres = n_nres + NW'(1);
                        end
                    end
                    if (n_nres >= NW'(b32ge_pkg::MAX_RESULTS)) begin
                        n_limit = 1'b1;
                    end else begin
                        n_res[n_nres[IW-1:0]] = b32ge_pkg::sym_to_char(sym[k]);
                        n_nres = n_nres + NW'(1);
                    end
                    n_chars = n_chars + 8'd1;
                    gf_inc  = {1'b0, n_gfill} + (GW+1)'(1);
                    n_gfill = ({1'b0, n_gfill} == GS_LAST) ? '0 : gf_inc[GW-1:0];
                end
            end
        end

        if (r_in_fin && n_nres == '0) begin
            n_nres = NW'(1);
        end

        n_residue = acc[3:0] & ((4'd1 << left) - 4'd1);
        n_rcnt    = left;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_chars <= b32ge_pkg::MAX_CHARS_RST;
            r_group_en  <= b32ge_pkg::GROUP_EN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                b32ge_pkg::CFG_MAX_CHARS: r_max_chars <= i_cfg_data;
                b32ge_pkg::CFG_GROUP_EN:  r_group_en  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready) begin
            r_in_byte <= i_in.payload.in_byte;
            r_in_fin  <= i_in.payload.final_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_residue <= '0;
            r_rcnt    <= '0;
            r_gfill   <= '0;
            r_chars   <= '0;
            r_limit   <= 1'b0;
        end else if (advance) begin
            if (r_in_fin) begin
                r_residue <= '0;
                r_rcnt    <= '0;
                r_gfill   <= '0;
                r_chars   <= '0;
                r_limit   <= 1'b0;
            end else begin
                r_residue <= n_residue;
                r_rcnt    <= n_rcnt;
                r_gfill   <= n_gfill;
                r_chars   <= n_chars;
                r_limit   <= n_limit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_valid <= 1'b0;
            r_buf_idx   <= '0;
        end else if (advance) begin
            r_buf_valid <= (n_nres != '0);
            r_buf_idx   <= '0;
        end else if (out_xfer) begin
            if (buf_last) begin
                r_buf_valid <= 1'b0;
            end
            r_buf_idx <= r_buf_idx + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_buf_char  <= n_res;
            r_buf_cnt   <= n_nres;
            r_buf_eot   <= r_in_fin;
            r_buf_trunc <= n_limit;
        end
    end

endmodule

FILE: tb/b32ge_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base32 grouped encoder checker
// Watches the byte and character channels and the register port. For every
// accepted byte it predicts the characters, spaces and closing result.
// Every character transfer is compared, field by field, with the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------
module b32ge_checker #(
    parameter int GROUP_SIZE = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  b32ge_pkg::t_in_item               i_in_item,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  b32ge_pkg::t_out_item              i_out_item,
    input  logic                              i_cfg_we,
    input  logic [b32ge_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [b32ge_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                                o_errors,
    output int                                o_pending,
    output int                                o_checked
);

    localparam logic [255:0] B32_ALPHABET = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";

    logic [7:0]  lim_chars;
    logic        grp_on;
    logic [11:0] residue;
    logic [2:0]  residue_bits;
    int          fill;
    logic [7:0]  sent;
    logic        trunc;

    logic [6:0]            step_chars[$];
    b32ge_pkg::t_out_item  expected_chars[$];
    int                    err_count;
    int                    check_count;

    function automatic void put_char(input logic [6:0] ch);
        if (step_chars.size() >= b32ge_pkg::MAX_RESULTS) begin
            trunc = 1'b1;
        end else begin
            step_chars.push_back(ch);
        end
    endfunction

    function automatic void emit_sym(input logic [4:0] sym);
        int pos;
        pos = 8 * (31 - int'(sym));
        if (sent >= lim_chars) begin
            trunc = 1'b1;
        end else begin
            if (fill == 0 && sent != 8'd0 && grp_on) begin
                put_char(b32ge_pkg::CHAR_SPACE);
            end
            put_char(B32_ALPHABET[pos +: 7]);
            sent = sent + 8'd1;
            fill = (fill + 1 >= GROUP_SIZE) ? 0 : fill + 1;
        end
    endfunction

    task automatic encode_byte(input b32ge_pkg::t_in_item it);
        logic [11:0]          acc;
        int                   nbits;
        b32ge_pkg::t_out_item r;
        step_chars.delete();
        nbits = (residue_bits > 3'd4) ? 4 : int'(residue_bits);
        acc = ((residue & ((12'd1 << nbits) - 12'd1)) << 8) | {4'd0, it.in_byte};
        nbits += 8;
        while (nbits >= 5) begin
            nbits -= 5;
            emit_sym(5'((acc >> nbits) & 12'h1F));
        end
        acc &= (12'd1 << nbits) - 12'd1;
        if (it.final_byte && nbits > 0) begin
            emit_sym(5'((acc << (5 - nbits)) & 12'h1F));
            nbits = 0;
            acc = '0;
        end
        if (it.final_byte && step_chars.size() == 0) begin
            step_chars.push_back(b32ge_pkg::CHAR_NUL);
        end
        foreach (step_chars[k]) begin
            r.out_char    = step_chars[k];
            r.end_of_text = it.final_byte && (k == step_chars.size() - 1);
            r.truncated   = trunc;
            expected_chars.push_back(r);
        end
        if (it.final_byte) begin
            residue      = '0;
            residue_bits = '0;
            fill         = 0;
            sent         = '0;
            trunc        = 1'b0;
        end else begin
            residue      = acc;
            residue_bits = 3'(nbits);
        end
    endtask

    always @(posedge i_clk) begin
        b32ge_pkg::t_out_item want;
        if (!i_rst_n) begin
            lim_chars    = b32ge_pkg::MAX_CHARS_RST;
            grp_on       = b32ge_pkg::GROUP_EN_RST;
            residue      = '0;
            residue_bits = '0;
            fill         = 0;
            sent         = '0;
            trunc        = 1'b0;
            expected_chars.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    b32ge_pkg::CFG_MAX_CHARS: lim_chars = i_cfg_data;
                    b32ge_pkg::CFG_GROUP_EN:  grp_on = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_chars.size() == 0) begin
                    $error("unexpected transfer: out_char %0h end_of_text %0b truncated %0b",
                           i_out_item.out_char, i_out_item.end_of_text,
                           i_out_item.truncated);
                    err_count++;
                end else begin
                    want = expected_chars.pop_front();
                    check_count++;
                    if (want.out_char !== i_out_item.out_char) begin
                        $error("out_char: expected %0h, actual %0h",
                               want.out_char, i_out_item.out_char);
                        err_count++;
                    end
                    if (want.end_of_text !== i_out_item.end_of_text) begin
                        $error("end_of_text: expected %0b, actual %0b",
                               want.end_of_text, i_out_item.end_of_text);
                        err_count++;
                    end
                    if (want.truncated !== i_out_item.truncated) begin
                        $error("truncated: expected %0b, actual %0b",
                               want.truncated, i_out_item.truncated);
                        err_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                encode_byte(i_in_item);
            end
        end
        o_errors  <= err_count;
        o_pending <= expected_chars.size();
        o_checked <= check_count;
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base32 grouped encoder testbench
// Drives key bytes into the encoder with random gaps and output stalls,
// steps through several limit and grouping settings, and leaves checking to
// the checker beside the encoder. Reports the verdict at the end.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 8;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              cfg_we;
    logic [b32ge_pkg::CFG_IDX_W-1:0]   cfg_idx;
    logic [b32ge_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                              calm;
    logic                              grp_now;

    int err_cnt;
    int pending_cnt;
    int checked_cnt;
    int cycle_count;
    int byte_count;
    int text_count;
    int setting_count;

    b32ge_stream_if #(.t_payload(b32ge_pkg::t_in_item))  byte_ch ();
    b32ge_stream_if #(.t_payload(b32ge_pkg::t_out_item)) char_ch ();

    base32_grouped_encoder #(.GROUP_SIZE(4)) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (byte_ch),
        .o_out      (char_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    b32ge_checker #(.GROUP_SIZE(4)) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (byte_ch.valid),
        .i_in_ready  (byte_ch.ready),
        .i_in_item   (byte_ch.payload),
        .i_out_valid (char_ch.valid),
        .i_out_ready (char_ch.ready),
        .i_out_item  (char_ch.payload),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_errors    (err_cnt),
        .o_pending   (pending_cnt),
        .o_checked   (checked_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("testbench NOT OK");
        $finish;
    end

    always @(posedge i_clk) begin
        char_ch.ready <= calm || ($urandom_range(0, 99) >= 17);
    end

    task automatic send_byte(input logic [7:0] b, input logic fin);
        b32ge_pkg::t_in_item it;
        it.in_byte    = b;
        it.final_byte = fin;
        while (!calm && $urandom_range(0, 99) < 17) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.payload <= it;
        do @(posedge i_clk); while (!byte_ch.ready);
        byte_count++;
        if (fin) text_count++;
    endtask

    // stop sending, wait for every predicted character, then let the block settle
    task automatic drain();
        byte_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [b32ge_pkg::CFG_IDX_W-1:0] idx,
                             input logic [b32ge_pkg::CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] lim, input logic grp);
        write_reg(b32ge_pkg::CFG_MAX_CHARS, lim);
        write_reg(b32ge_pkg::CFG_GROUP_EN, {7'($urandom), grp});
        cfg_we  <= 1'b0;
        grp_now = grp;
        setting_count++;
    endtask

    task automatic send_text(input int len);
        for (int k = 0; k < len; k++) begin
            send_byte(8'($urandom), k == len - 1);
            if (k != len - 1 && $urandom_range(0, 24) == 0) begin
                // flip grouping in the middle of a text
                drain();
                write_reg(b32ge_pkg::CFG_GROUP_EN, {7'($urandom), !grp_now});
                cfg_we  <= 1'b0;
                grp_now = !grp_now;
                setting_count++;
            end
        end
        if ($urandom_range(0, 39) == 0) drain();
    endtask

    initial begin
        int          phase_bytes;
        logic [7:0]  lim;
        logic        grp;

        i_rst_n         <= 1'b0;
        byte_ch.valid   <= 1'b0;
        byte_ch.payload <= '0;
        cfg_we          <= 1'b0;
        cfg_idx         <= '0;
        cfg_data        <= '0;
        calm            = 1'b0;
        grp_now         = b32ge_pkg::GROUP_EN_RST;
        byte_count      = 0;
        text_count      = 0;
        setting_count   = 1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: 127 characters, grouping on
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h3C, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b1);
        send_byte(8'h66, 1'b0);
        send_byte(8'h6F, 1'b0);
        send_byte(8'h6F, 1'b1);
        drain();

        // limit of one: final byte fully suppressed gives a closing result
        set_config(8'd1, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        drain();

        // limit of zero suppresses every character; only the closing result is left
        set_config(8'd0, 1'b1);
        send_byte(8'h55, 1'b1);
        drain();

        set_config(8'd255, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b0);
        send_byte(8'h78, 1'b0);
        send_byte(8'h9A, 1'b0);
        send_byte(8'hBC, 1'b1);
        drain();

        set_config(8'd5, 1'b1);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'hC3, 1'b1);
        drain();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin lim = 8'd1;   grp = 1'b1; end
                1: begin lim = 8'd255; grp = 1'b0; end
                2: begin lim = 8'd127; grp = 1'b1; end
                default: begin
                    lim = 8'($urandom_range(2, 40));
                    grp = 1'($urandom_range(0, 1));
                end
            endcase
            set_config(lim, grp);
            calm = (p == 3);
            phase_bytes = byte_count;
            while (byte_count - phase_bytes < 50) begin
                if ($urandom_range(0, 7) == 0) begin
                    send_text($urandom_range(11, 40));
                end else begin
                    send_text($urandom_range(1, 10));
                end
            end
            drain();
        end
        calm = 1'b0;

        $display("covered %0d bytes in %0d texts over %0d register settings",
                 byte_count, text_count, setting_count);
        $display("%0d characters checked, limits from 0 to 255, grouping on and off",
                 checked_cnt);
        if (err_cnt == 0 && pending_cnt == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
